@@ design/rcp_pkg.sv @@
package rcp_pkg;

  localparam int MaxToken = 64;
  localparam int MaxArgs  = 255;
  localparam int InDepth  = 2;
  localparam int OutDepth = 4;

  localparam logic [63:0] SatMag = 64'h8000_0000_0000_0000;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDol   = 8'h24;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef enum logic [2:0] {
    EV_CMD  = 3'd0,
    EV_NUM  = 3'd1,
    EV_BYTE = 3'd2,
    EV_SEND = 3'd3,
    EV_DONE = 3'd4,
    EV_ERR  = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ERR_HDR  = 3'd0,
    ERR_TOK  = 3'd1,
    ERR_BULK = 3'd2,
    ERR_CMD  = 3'd3,
    ERR_ARG  = 3'd4
  } err_e;

  typedef enum logic [12:0] {
    PH_HDR       = 13'b0000000000001,
    PH_HDR_NUM   = 13'b0000000000010,
    PH_LF_TYPE   = 13'b0000000000100,
    PH_TYPE      = 13'b0000000001000,
    PH_NUM_PRE   = 13'b0000000010000,
    PH_NUM_DIG   = 13'b0000000100000,
    PH_NUM_TAIL  = 13'b0000001000000,
    PH_SIMPLE    = 13'b0000010000000,
    PH_BULK_LEN  = 13'b0000100000000,
    PH_BULK_LF   = 13'b0001000000000,
    PH_BULK_BODY = 13'b0010000000000,
    PH_TRAIL_CR  = 13'b0100000000000,
    PH_TRAIL_LF  = 13'b1000000000000
  } phase_e;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_cr;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  arg;
    logic [63:0] num;
    logic [7:0]  sbyte;
    err_e        err;
    logic        last;
  } res_t;

  function automatic logic [7:0] ping_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h50;
      2'd1:    ch = 8'h49;
      2'd2:    ch = 8'h4E;
      default: ch = 8'h47;
    endcase
    return ch;
  endfunction

endpackage

@@ design/rcp_front.sv @@
module rcp_front import rcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       tok_valid_o,
  input  logic       tok_take_i,
  output tok_t       tok_o
);

  tok_t       mem_q [InDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  tok_t       cls;

  // classify on entry so the parser sees flags, not raw compares
  always_comb begin
    cls.data     = data_byte_i;
    cls.is_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChZero + 8'd9);
    cls.is_cr    = (data_byte_i == ChCr);
    cls.digit    = 4'(data_byte_i - ChZero);
  end

  assign in_ready_o  = (cnt_q != 2'(InDepth));
  assign push        = in_valid_i && in_ready_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign pop         = tok_valid_o && tok_take_i;
  assign tok_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/rcp_back.sv @@
module rcp_back import rcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  output logic       tok_take_o,
  input  tok_t       tok_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  phase_e      ph_q, ph_d;
  logic [7:0]  args_q, args_d;
  logic [6:0]  len_q, len_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  cur_q, cur_d;

  res_t        oq_q [OutDepth];
  logic [1:0]  owp_q, orp_q;
  logic [2:0]  ocnt_q;

  logic        take, pop, named, grow_ok, clr;
  logic [1:0]  nres;
  res_t        r0, r1;
  logic [67:0] acc10;
  logic [63:0] acc_next, fin_val;
  logic [7:0]  c;

  assign take        = tok_valid_i && (ocnt_q <= 3'(OutDepth - 2));
  assign tok_take_o  = take;
  assign res_valid_o = (ocnt_q != 3'd0);
  assign pop         = res_valid_o && res_ready_i;
  assign res_o       = oq_q[orp_q];

  assign c       = tok_i.data;
  assign named   = (pos_q == 3'd4);
  assign grow_ok = (len_q < 7'(MaxToken - 1));

  // acc*10 + d saturates at 2^63 exactly where the strtol check trips
  assign acc10    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {64'd0, tok_i.digit};
  assign acc_next = (acc10 > {4'd0, SatMag}) ? SatMag : acc10[63:0];

  always_comb begin
    if (neg_q) fin_val = (acc_q >= SatMag) ? SatMag : (64'd0 - acc_q);
    else       fin_val = (acc_q > SatMag - 64'd1) ? SatMag - 64'd1 : acc_q;
  end

  always_comb begin
    ph_d   = ph_q;
    args_d = args_q;
    len_d  = len_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    pos_d  = pos_q;
    cur_d  = cur_q;
    nres   = 2'd0;
    clr    = 1'b0;
    r0     = '0;
    r0.arg = cur_q;
    r1     = '0;
    r1.arg = cur_q;
    if (take) begin
      case (ph_q)
        PH_HDR: begin
          if (c != ChStar) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_HDR; clr = 1'b1;
          end else begin
            len_d = 7'd1; acc_d = '0; ph_d = PH_HDR_NUM;
          end
        end
        PH_HDR_NUM: begin
          if (tok_i.is_cr) begin
            if (acc_q == '0 || acc_q > 64'(MaxArgs + 1)) begin
              nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_HDR; clr = 1'b1;
            end else begin
              args_d = acc_q[7:0] - 8'd1;
              ph_d   = PH_LF_TYPE;
            end
          end else if (!grow_ok) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_TOK; clr = 1'b1;
          end else if (tok_i.is_digit) begin
            len_d = len_q + 7'd1; acc_d = acc_next;
          end else begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_HDR; clr = 1'b1;
          end
        end
        PH_LF_TYPE: ph_d = PH_TYPE;
        PH_TYPE: begin
          len_d = 7'd1; acc_d = '0; neg_d = 1'b0;
          if (!named) begin
            if (c == ChDol) ph_d = PH_BULK_LEN;
            else begin
              nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_CMD; clr = 1'b1;
            end
          end else if (c == ChDol || c == ChColon || c == ChPlus) begin
            if (c == ChDol)        ph_d = PH_BULK_LEN;
            else if (c == ChColon) ph_d = PH_NUM_PRE;
            else                   ph_d = PH_SIMPLE;
            args_d = args_q - 8'd1;
          end else begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_ARG; clr = 1'b1;
          end
        end
        PH_NUM_PRE, PH_NUM_DIG, PH_NUM_TAIL: begin
          if (tok_i.is_cr) begin
            nres = 2'd1; r0.ev = EV_NUM; r0.num = fin_val;
            cur_d = cur_q + 8'd1; ph_d = PH_TRAIL_LF;
          end else if (!grow_ok) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_TOK; clr = 1'b1;
          end else begin
            len_d = len_q + 7'd1;
            if (ph_q == PH_NUM_TAIL) begin
              // trailing junk ignored
            end else if (tok_i.is_digit) begin
              acc_d = acc_next; ph_d = PH_NUM_DIG;
            end else if (ph_q == PH_NUM_PRE && (c == ChSpace || c inside {[8'd9:8'd12]})) begin
              // leading white space
            end else if (ph_q == PH_NUM_PRE && (c == ChPlus || c == ChMinus)) begin
              neg_d = (c == ChMinus); ph_d = PH_NUM_DIG;
            end else begin
              ph_d = PH_NUM_TAIL;
            end
          end
        end
        PH_SIMPLE: begin
          if (tok_i.is_cr) begin
            nres = 2'd1; r0.ev = EV_SEND;
            cur_d = cur_q + 8'd1; ph_d = PH_TRAIL_LF;
          end else if (!grow_ok) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_TOK; clr = 1'b1;
          end else begin
            len_d = len_q + 7'd1;
            nres = 2'd1; r0.ev = EV_BYTE; r0.sbyte = c;
          end
        end
        PH_BULK_LEN: begin
          if (tok_i.is_cr) begin
            if (acc_q >= 64'(MaxToken)) begin
              nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_BULK; clr = 1'b1;
            end else if (!named && acc_q != 64'd4) begin
              nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_CMD; clr = 1'b1;
            end else begin
              len_d = acc_q[6:0]; ph_d = PH_BULK_LF;
            end
          end else if (!grow_ok) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_TOK; clr = 1'b1;
          end else if (tok_i.is_digit) begin
            len_d = len_q + 7'd1; acc_d = acc_next;
          end else begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = named ? ERR_ARG : ERR_CMD; clr = 1'b1;
          end
        end
        PH_BULK_LF: begin
          if (len_q == '0) begin
            nres = 2'd1; r0.ev = EV_SEND;
            cur_d = cur_q + 8'd1; ph_d = PH_TRAIL_CR;
          end else begin
            ph_d = PH_BULK_BODY;
          end
        end
        PH_BULK_BODY: begin
          if (named) begin
            nres = 2'd1; r0.ev = EV_BYTE; r0.sbyte = c;
            len_d = len_q - 7'd1;
            if (len_q == 7'd1) begin
              nres = 2'd2; r1.ev = EV_SEND;
              cur_d = cur_q + 8'd1; ph_d = PH_TRAIL_CR;
            end
          end else if (c != ping_char(pos_q[1:0])) begin
            nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_CMD; clr = 1'b1;
          end else begin
            pos_d = pos_q + 3'd1;
            len_d = len_q - 7'd1;
            if (pos_q == 3'd3) begin
              nres = 2'd1; r0.ev = EV_CMD; ph_d = PH_TRAIL_CR;
            end
          end
        end
        PH_TRAIL_CR: ph_d = PH_TRAIL_LF;
        PH_TRAIL_LF: begin
          if (args_q == '0) begin
            nres = 2'd1; r0.ev = EV_DONE; clr = 1'b1;
          end else begin
            ph_d = PH_TYPE;
          end
        end
        default: begin
          nres = 2'd1; r0.ev = EV_ERR; r0.err = ERR_HDR; clr = 1'b1;
        end
      endcase
      if (clr) begin
        ph_d = PH_HDR; args_d = '0; len_d = '0; acc_d = '0;
        neg_d = 1'b0; pos_d = '0; cur_d = '0;
      end
      if (nres == 2'd2) r1.last = 1'b1;
      else              r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) oq_q[owp_q] <= r0;
    if (nres == 2'd2) oq_q[owp_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR;
      args_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      pos_q  <= '0;
      cur_q  <= '0;
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      ph_q   <= ph_d;
      args_q <= args_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      pos_q  <= pos_d;
      cur_q  <= cur_d;
      owp_q  <= owp_q + nres;
      if (pop) orp_q <= orp_q + 2'd1;
      ocnt_q <= ocnt_q + {1'b0, nres} - 3'(pop);
    end
  end

endmodule

@@ design/resp_command_parser_core.sv @@
// RESP request parser, one byte per transaction on the input channel. It
// checks an array header "*N", a bulk command name that must be exactly
// "PING", then N-1 arguments (":" integer, "$" bulk, "+" simple), and emits
// events: command accepted, integer value (strtol-style, saturated to signed
// 64 bits), string byte, string end, done, or an error code, after which it
// waits for the next "*". A byte yields up to two result transactions; last_o
// marks the final one. Rate: one byte per cycle while the result queue has
// room for two results. A two-entry input queue with byte classification
// feeds the parser, whose results wait in a four-entry result queue. Each
// byte is registered in the input queue and its results in the result queue.
module resp_command_parser_core import rcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic [7:0]         arg_index_o,
  output logic signed [63:0] number_value_o,
  output logic [7:0]         string_byte_o,
  output logic [2:0]         error_code_o,
  output logic               last_o
);

  logic tok_valid, tok_take;
  tok_t tok;
  res_t res;

  // front: input queue and byte classification
  rcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .tok_valid_o (tok_valid),
    .tok_take_i  (tok_take),
    .tok_o       (tok)
  );

  // back: parser state machine and result queue
  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_take_o  (tok_take),
    .tok_i       (tok),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign event_res_o    = res.ev;
  assign arg_index_o    = res.arg;
  assign number_value_o = res.num;
  assign string_byte_o  = res.sbyte;
  assign error_code_o   = res.err;
  assign last_o         = res.last;

endmodule
